/* rtl/core/cmm_pkg.sv */
// shared constants and types for the 2x2 complex matrix multiply core
// no dependencies; imported by every module of the block
`default_nettype none

package cmm_pkg;

  // default sample width of one real or imaginary part, Q1.15
  localparam int SAMPLE_WIDTH_DEF = 16;

  // elements per 2x2 matrix and the counter that walks them
  localparam int ELEMS = 4;
  localparam int CNT_W = $clog2(ELEMS);

  // one complex product per step, two steps per result element
  localparam int STEPS  = 2 * ELEMS;
  localparam int STEP_W = $clog2(STEPS);

  // fields per element in a queued job: a_re, a_im, b_re, b_im
  localparam int FIELDS = 4;

  // depth of the job queue between front and back
  localparam int QDEPTH = 2;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } cmm_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/cmm_front.sv */
// front end: accepts element requests, holds the first three elements of a matrix
// pair and pushes the complete pair as one job; depends on cmm_pkg
`default_nettype none

module cmm_front
  import cmm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic        [SAMPLE_WIDTH-1:0]          a_real_i,
  input  wire logic        [SAMPLE_WIDTH-1:0]          a_imag_i,
  input  wire logic        [SAMPLE_WIDTH-1:0]          b_real_i,
  input  wire logic        [SAMPLE_WIDTH-1:0]          b_imag_i,
  input  wire cmm_qstat_t                              qstat_i,
  output logic                                         push_o,
  output logic [ELEMS*FIELDS*SAMPLE_WIDTH-1:0]         job_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(ELEMS - 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_pos;
  logic             accept;

  // element store for positions before the last one
  logic [SW-1:0] ar_q [ELEMS-1];
  logic [SW-1:0] ai_q [ELEMS-1];
  logic [SW-1:0] br_q [ELEMS-1];
  logic [SW-1:0] bi_q [ELEMS-1];

  // the last element needs room in the queue, earlier ones never stall
  assign last_pos   = (cnt_q == LAST_POS);
  assign in_ready_o = !last_pos || !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && last_pos;
  assign cnt_d      = accept ? cnt_q + CNT_W'(1) : cnt_q;

  // element position counter, wraps after the fourth element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // store writes, no reset on payload
  always_ff @(posedge clk_i) begin
    if (accept && !last_pos) begin
      ar_q[cnt_q] <= a_real_i;
      ai_q[cnt_q] <= a_imag_i;
      br_q[cnt_q] <= b_real_i;
      bi_q[cnt_q] <= b_imag_i;
    end
  end

  // job packing: per element a_re, a_im, b_re, b_im from the lowest bit up
  always_comb begin
    job_o = '0;
    for (int e = 0; e < ELEMS - 1; e++) begin
      job_o[(e*FIELDS + 0)*SW +: SW] = ar_q[e];
      job_o[(e*FIELDS + 1)*SW +: SW] = ai_q[e];
      job_o[(e*FIELDS + 2)*SW +: SW] = br_q[e];
      job_o[(e*FIELDS + 3)*SW +: SW] = bi_q[e];
    end
    job_o[((ELEMS-1)*FIELDS + 0)*SW +: SW] = a_real_i;
    job_o[((ELEMS-1)*FIELDS + 1)*SW +: SW] = a_imag_i;
    job_o[((ELEMS-1)*FIELDS + 2)*SW +: SW] = b_real_i;
    job_o[((ELEMS-1)*FIELDS + 3)*SW +: SW] = b_imag_i;
  end

endmodule

`default_nettype wire

/* rtl/core/cmm_queue.sv */
// short job queue between front and back, register based
// depends on cmm_pkg for depth and status type
`default_nettype none

module cmm_queue
  import cmm_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] head_o,
  output cmm_qstat_t            qstat_o
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  logic [WIDTH-1:0]  slot_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_QW'(1);
      2'b01:   cnt_d = cnt_q - CNT_QW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // job slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o        = slot_q[rd_ptr_q];
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == CNT_QW'(QDEPTH));

endmodule

`default_nettype wire

/* rtl/core/cmm_back.sv */
// back end: complex multiply-accumulate over the queued job, eight complex products
// per pair, one per cycle unless stalled, and result register; depends on cmm_pkg
`default_nettype none

module cmm_back
  import cmm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = ((2*SAMPLE_WIDTH + 2) > 64) ? 64 : (2*SAMPLE_WIDTH + 2)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [ELEMS*FIELDS*SAMPLE_WIDTH-1:0] job_i,
  input  wire cmm_qstat_t                          qstat_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [OUT_WIDTH-1:0]                prod_real_o,
  output logic      [OUT_WIDTH-1:0]                prod_imag_o,
  output logic                                     last_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = 2 * SW;
  localparam int AW = 2 * SW + 2;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
  localparam logic [CNT_W-1:0]  K_LAST    = CNT_W'(ELEMS - 1);

  logic              en;
  logic              issue;
  logic [STEP_W-1:0] step_q, step_d;

  logic              term;
  logic [CNT_W-1:0]  a_idx, b_idx;
  logic signed [SW-1:0] ar, ai, br, bi;

  // stage 1: partial products
  logic                 s1_valid_q;
  logic                 s1_term_q;
  logic [CNT_W-1:0]     s1_k_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  // stage 2: one complex product
  logic                 s2_valid_q;
  logic                 s2_term_q;
  logic [CNT_W-1:0]     s2_k_q;
  logic signed [AW-1:0] c_re_q, c_im_q, c_re_d, c_im_d;

  // stage 3: accumulator and result register
  logic signed [AW-1:0] acc_re_q, acc_im_q;
  logic signed [AW-1:0] sum_re, sum_im;
  logic                 out_valid_q;
  logic [OUT_WIDTH-1:0] out_re_q, out_im_q;
  logic                 out_last_q;

  // the whole pipe moves whenever the result register can take a new value
  assign en     = !out_valid_q || out_ready_i;
  assign issue  = en && !qstat_i.empty;
  assign pop_o  = issue && (step_q == STEP_LAST);
  assign step_d = issue ? step_q + STEP_W'(1) : step_q;

  // step: bit 0 picks the inner term, bits above pick the result element
  assign term  = step_q[0];
  assign a_idx = {term, step_q[1]};
  assign b_idx = {step_q[2], term};

  // operand select from the head job
  always_comb begin
    ar = job_i[(int'(a_idx)*FIELDS + 0)*SW +: SW];
    ai = job_i[(int'(a_idx)*FIELDS + 1)*SW +: SW];
    br = job_i[(int'(b_idx)*FIELDS + 2)*SW +: SW];
    bi = job_i[(int'(b_idx)*FIELDS + 3)*SW +: SW];
  end

  // complex product from registered partials
  assign c_re_d = {{2{p_rr_q[PW-1]}}, p_rr_q} - {{2{p_ii_q[PW-1]}}, p_ii_q};
  assign c_im_d = {{2{p_ri_q[PW-1]}}, p_ri_q} + {{2{p_ir_q[PW-1]}}, p_ir_q};

  // second term completes the element
  assign sum_re = acc_re_q + c_re_q;
  assign sum_im = acc_im_q + c_im_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (en) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q && s2_term_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_term_q <= term;
      s1_k_q    <= step_q[STEP_W-1:1];
      p_rr_q    <= ar * br;
      p_ii_q    <= ai * bi;
      p_ri_q    <= ar * bi;
      p_ir_q    <= ai * br;
      s2_term_q <= s1_term_q;
      s2_k_q    <= s1_k_q;
      c_re_q    <= c_re_d;
      c_im_q    <= c_im_d;
      if (s2_valid_q && !s2_term_q) begin
        acc_re_q <= c_re_q;
        acc_im_q <= c_im_q;
      end
      if (s2_valid_q && s2_term_q) begin
        out_re_q   <= sum_re[OUT_WIDTH-1:0];
        out_im_q   <= sum_im[OUT_WIDTH-1:0];
        out_last_q <= (s2_k_q == K_LAST);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign prod_real_o = out_re_q;
  assign prod_imag_o = out_im_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/complex_matmul_2x2_batch_core.sv */
// 2x2 complex matrix multiply, C = A*B, column-major, Q1.15 in, Q4.30 out
// the fourth request pushes a pair as a job; each product passes the partial-product,
// complex-product and result registers; the single complex multiply-accumulate in the
// back end sets the rate, eight products per pair, and overlaps consecutive pairs
// reset: counters, queue and valids clear; element store and queue slots hold no reset
// depends on cmm_pkg, cmm_front, cmm_queue, cmm_back
`default_nettype none

module complex_matmul_2x2_batch_core
  import cmm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = ((2*SAMPLE_WIDTH + 2) > 64) ? 64 : (2*SAMPLE_WIDTH + 2),
  parameter int IN_TW        = ((FIELDS*SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int OUT_TW       = ((2*OUT_WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // a_real, a_imag, b_real, b_imag from the lowest bit up
  input  wire logic [IN_TW-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // prod_real, prod_imag from the lowest bit up
  output logic      [OUT_TW-1:0] m_axis_tdata_o,
  // last_of_matrix
  output logic                   m_axis_tlast_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int JW = ELEMS * FIELDS * SW;

  logic             push;
  logic             pop;
  logic [JW-1:0]    job_in, job_head;
  cmm_qstat_t       qstat;
  logic [OUT_WIDTH-1:0] prod_re, prod_im;

  // front end
  cmm_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .a_real_i   (s_axis_tdata_i[0*SW +: SW]),
    .a_imag_i   (s_axis_tdata_i[1*SW +: SW]),
    .b_real_i   (s_axis_tdata_i[2*SW +: SW]),
    .b_imag_i   (s_axis_tdata_i[3*SW +: SW]),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_o      (job_in)
  );

  // job queue
  cmm_queue #(
    .WIDTH(JW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job_in),
    .pop_i       (pop),
    .head_o      (job_head),
    .qstat_o     (qstat)
  );

  // back end
  cmm_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .OUT_WIDTH   (OUT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .prod_real_o (prod_re),
    .prod_imag_o (prod_im),
    .last_o      (m_axis_tlast_o)
  );

  // result packing
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[0 +: OUT_WIDTH]         = prod_re;
    m_axis_tdata_o[OUT_WIDTH +: OUT_WIDTH] = prod_im;
  end

`ifndef SYNTHESIS
  // the front only stalls requests when the queue has no room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> qstat.full)
    else $error("request stalled while queue has room");

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full queue");

  // the back never retires a job that is not there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
